// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the positioner RTL.
// No dependencies; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed: label");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed: label");
`endif

// ----- rtl/core/ptp_pkg.sv -----
// Package for the pan/tilt positioner: types, constants and helpers.
// No dependencies.
package ptp_pkg;
    localparam int TableDepth = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam logic signed [17:0] FullTurn = 18'sd46080;
    localparam logic signed [17:0] HalfTurn = 18'sd23040;
    localparam logic signed [15:0] IdleTilt = 16'sd1920;

    // Division by a full turn: shift out 1024, then multiply by a reciprocal of 45.
    // The bias keeps the reciprocal operand positive; it is 45 times FloorQBias.
    localparam logic signed [23:0] FloorRecip = 24'sd5965233;
    localparam logic signed [23:0] FloorBias = 24'sd1474560;
    localparam logic signed [17:0] FloorQBias = 18'sd32768;
    localparam int FloorShift = 28;

    typedef enum logic [2:0] {
        CFG_PAN_MIN = 3'd0,
        CFG_PAN_MAX = 3'd1,
        CFG_TILT_MAX = 3'd2,
        CFG_TILT_MIN_BASE = 3'd3,
        CFG_LIMIT_COUNT = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_PAN, S_FL_CUR, S_FL_CUR_W, S_TILT, S_FL_TGT, S_FL_TGT_W, S_DONE
    } t_state;

    typedef enum logic [2:0] {F_IDLE, F_IDX, F_MUL0, F_MUL1, F_DIV, F_OUT} t_fstate;

    typedef struct packed {
        logic start;
        logic signed [15:0] angle;
    } t_floor_req;

    typedef struct packed {
        logic done;
        logic signed [15:0] value;
    } t_floor_rsp;

    // Wrap a sum in (-69120, 69120] into (-23040, 23040].
    function automatic logic signed [15:0] f_rewrap(input logic signed [17:0] v);
        logic signed [17:0] m;
        begin
            m = v;
            if (m > HalfTurn) m = m - FullTurn;
            else if (m <= -HalfTurn) m = m + FullTurn;
            return m[15:0];
        end
    endfunction

    // Move pos toward target by at most step.
    function automatic logic signed [15:0] f_slew(input logic signed [15:0] pos,
            input logic signed [15:0] tgt, input logic [14:0] step);
        logic signed [17:0] d;
        logic signed [17:0] mag;
        begin
            d = 18'(tgt) - 18'(pos);
            if (d > HalfTurn) d = d - FullTurn;
            else if (d < -HalfTurn) d = d + FullTurn;
            mag = (d < 0) ? -d : d;
            if (mag <= 18'(step)) return f_rewrap(18'(tgt));
            if (d < 0) return f_rewrap(18'(pos) - 18'(step));
            return f_rewrap(18'(pos) + 18'(step));
        end
    endfunction

    function automatic logic signed [15:0] f_clamp(input logic signed [15:0] x,
            input logic signed [15:0] lo, input logic signed [15:0] hi);
        begin
            if (x < lo) return lo;
            if (x < hi) return x;
            return hi;
        end
    endfunction
endpackage

// ----- rtl/core/pan_tilt_slew_limited_positioner.sv -----
// Pan/tilt positioner with slew limit and pan-dependent tilt floor.
// An aim request runs S_PAN, a floor lookup at the current pan, S_TILT and a
// floor lookup at the target pan; a table write runs only the first lookup.
// One request is in work at a time: ready is low while a request is in work
// and returns after the result is taken.
// Reset (synchronous, active low) clears the positions and config registers;
// the floor table is not cleared.
`include "assert_macros.svh"
module pan_tilt_slew_limited_positioner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic                i_aim_valid,
    input  logic signed [15:0]  i_target_pan,
    input  logic signed [15:0]  i_target_tilt,
    input  logic [14:0]         i_max_step,
    input  logic [3:0]          i_entry_index,
    input  logic signed [14:0]  i_entry_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_pan_angle,
    output logic signed [15:0]  o_tilt_angle,
    output logic signed [15:0]  o_tilt_floor,
    output logic                o_reachable,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import ptp_pkg::*;

    t_state r_st, n_st;
    logic signed [15:0] r_pan_min, r_pan_max, r_tilt_max, r_tilt_base;
    logic [4:0] r_lcount;
    logic signed [15:0] r_pan, r_tilt, r_fl;
    logic r_op;
    logic signed [15:0] r_tp, r_tt;
    logic [14:0] r_step;
    logic r_reach;
    t_floor_req w_req;
    t_floor_rsp w_rsp;
    logic w_acc;

    assign w_acc = i_valid && o_ready;
    // Registers change only while no request is in work or being offered.
    assign o_cfg_ready = (r_st == S_IDLE) && !i_valid;
    assign o_ready = (r_st == S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_min <= -16'sd23040;
            r_pan_max <= 16'sd23040;
            r_tilt_max <= 16'sd11520;
            r_tilt_base <= '0;
            r_lcount <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PAN_MIN: r_pan_min <= i_cfg_data;
                CFG_PAN_MAX: r_pan_max <= i_cfg_data;
                CFG_TILT_MAX: r_tilt_max <= i_cfg_data;
                CFG_TILT_MIN_BASE: r_tilt_base <= i_cfg_data;
                CFG_LIMIT_COUNT: r_lcount <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    ptp_floor u_floor (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .i_wr_en(w_acc && i_opcode), .i_wr_idx(i_entry_index),
        .i_wr_val(i_entry_value), .i_limit_count(r_lcount),
        .i_min_base(r_tilt_base), .o_rsp(w_rsp)
    );

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:     if (w_acc) n_st = i_opcode ? S_FL_CUR : S_PAN;
            S_PAN:      n_st = S_FL_CUR;
            S_FL_CUR:   n_st = S_FL_CUR_W;
            S_FL_CUR_W: if (w_rsp.done) n_st = r_op ? S_DONE : S_TILT;
            S_TILT:     n_st = S_FL_TGT;
            S_FL_TGT:   n_st = S_FL_TGT_W;
            S_FL_TGT_W: if (w_rsp.done) n_st = S_DONE;
            S_DONE:     if (i_ready) n_st = S_IDLE;
            default:    n_st = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_req.start = (r_st == S_FL_CUR) || (r_st == S_FL_TGT);
        w_req.angle = (r_st == S_FL_TGT) ? r_tp : r_pan;
        o_valid = (r_st == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_pan <= '0;
            r_tilt <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                S_PAN: r_pan <= f_slew(r_pan, f_clamp(r_tp, r_pan_min, r_pan_max),
                                       r_step);
                S_TILT: r_tilt <= f_slew(r_tilt, f_clamp(r_tt, r_fl, r_tilt_max),
                                         r_step);
                default: ;
            endcase
        end
    end

    // Request capture and result fields.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op <= i_opcode;
            r_tp <= i_aim_valid ? i_target_pan : '0;
            r_tt <= i_aim_valid ? i_target_tilt : IdleTilt;
            r_step <= i_max_step;
            r_reach <= 1'b0;
        end
        if (r_st == S_FL_CUR_W && w_rsp.done) begin
            r_fl <= w_rsp.value;
            r_reach <= !r_op && !(r_tp > r_pan_max || r_tp < r_pan_min)
                       && !(r_tt > r_tilt_max);
        end
        if (r_st == S_FL_TGT_W && w_rsp.done && r_tt < w_rsp.value) r_reach <= 1'b0;
    end

    assign o_pan_angle = r_pan;
    assign o_tilt_angle = r_tilt;
    assign o_tilt_floor = r_fl;
    assign o_reachable = r_reach;

    `CHK_IMPL(a_ready_idle, i_clk, i_rst_n, o_valid, !o_ready)
    `CHK_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_pan_angle))
    `CHK_IMPL(a_pan_range, i_clk, i_rst_n, o_valid, o_pan_angle > -16'sd23040)
endmodule

// ----- rtl/core/ptp_floor.sv -----
// Tilt floor unit: table interpolation over pan angle on one shared multiplier.
// Depends on ptp_pkg. Holds the floor table in registers.
module ptp_floor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptp_pkg::t_floor_req  i_req,
    input  logic                 i_wr_en,
    input  logic [3:0]           i_wr_idx,
    input  logic signed [14:0]   i_wr_val,
    input  logic [4:0]           i_limit_count,
    input  logic signed [15:0]   i_min_base,
    output ptp_pkg::t_floor_rsp  o_rsp
);
    import ptp_pkg::*;

    logic signed [14:0] r_table [TableDepth];
    t_fstate r_fs, n_fs;
    logic [4:0] r_n;
    logic signed [21:0] r_p;
    logic [15:0] r_ar;
    logic signed [14:0] r_t1, r_t2;
    logic signed [31:0] r_acc;
    logic [16:0] r_quo;

    logic [4:0] w_n;
    logic signed [5:0] w_ns;
    logic signed [22:0] w_ps;
    logic signed [5:0] w_k;
    logic signed [21:0] w_r;
    logic [15:0] w_ar;
    logic signed [5:0] w_k2;
    logic [IdxW-1:0] w_i1, w_i2;
    logic signed [23:0] w_ma, w_mb;
    logic signed [47:0] w_prod;
    logic signed [23:0] w_biased;
    logic signed [15:0] w_local;

    // Table writes.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_table[i_wr_idx[IdxW-1:0]] <= i_wr_val;
    end

    assign w_n = (i_limit_count > 5'(TableDepth)) ? 5'(TableDepth) : i_limit_count;
    assign w_ns = $signed({1'b0, r_n});

    // Sector index and residue of the scaled angle.
    always_comb begin
        w_ps = 23'(r_p) + 23'(HalfTurn);
        w_k = '0;
        for (int j = -8; j <= 8; j++) begin
            if (w_ps >= 23'(j) * 23'(FullTurn)) w_k = 6'(j);
        end
        w_r = r_p - 22'(w_k) * 22'(FullTurn);
        w_ar = 16'((w_r < 0) ? -w_r : w_r);
        w_k2 = (w_r > 0) ? w_k + 6'sd1 : w_k - 6'sd1;
        w_i1 = (w_k < 0) ? IdxW'(w_k + w_ns) : (w_k >= w_ns) ?
               IdxW'(w_k - w_ns) : IdxW'(w_k);
        w_i2 = (w_k2 < 0) ? IdxW'(w_k2 + w_ns) : (w_k2 >= w_ns) ?
               IdxW'(w_k2 - w_ns) : IdxW'(w_k2);
    end

    // Shared multiplier: two interpolation weights, then the reciprocal divide.
    always_comb begin
        w_biased = 24'(r_acc >>> 10) + FloorBias;
        unique case (r_fs)
            F_MUL0: begin
                w_ma = 24'(r_t1);
                w_mb = 24'(FullTurn) - 24'($signed({1'b0, r_ar}));
            end
            F_MUL1: begin
                w_ma = 24'(r_t2);
                w_mb = 24'($signed({1'b0, r_ar}));
            end
            F_DIV: begin
                w_ma = w_biased;
                w_mb = FloorRecip;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = 48'(w_ma) * 48'(w_mb);
        w_local = 16'($signed({1'b0, r_quo}) - FloorQBias);
    end

    // Controller for one floor lookup.
    always_comb begin
        n_fs = r_fs;
        unique case (r_fs)
            F_IDLE: if (i_req.start) n_fs = F_IDX;
            F_IDX:  n_fs = F_MUL0;
            F_MUL0: n_fs = F_MUL1;
            F_MUL1: n_fs = F_DIV;
            F_DIV:  n_fs = F_OUT;
            F_OUT:  n_fs = F_IDLE;
            default: n_fs = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= F_IDLE;
        end else begin
            r_fs <= n_fs;
        end
    end

    // Datapath: scale, fetch both entries, weight them, divide by a full turn.
    always_ff @(posedge i_clk) begin
        unique case (r_fs)
            F_IDLE: begin
                r_p <= 22'(i_req.angle) * 22'($signed({1'b0, w_n}));
                r_n <= w_n;
            end
            F_IDX: begin
                r_ar <= w_ar;
                r_t1 <= r_table[w_i1];
                r_t2 <= r_table[w_i2];
            end
            F_MUL0: r_acc <= 32'(w_prod) + 32'(HalfTurn);
            F_MUL1: r_acc <= r_acc + 32'(w_prod);
            F_DIV:  r_quo <= w_prod[FloorShift +: 17];
            default: ;
        endcase
    end

    // Response: larger of interpolated value and base minimum; base if count 0.
    always_comb begin
        o_rsp.done = (r_fs == F_OUT);
        o_rsp.value = (r_n != 5'd0 && w_local > i_min_base) ? w_local : i_min_base;
    end
endmodule
